// ===== hdl/vegetation_index_pixel_defines.svh =====
// Assertion macros for the vegetation index pixel checker
`ifndef VEGETATION_INDEX_PIXEL_DEFINES_SVH
`define VEGETATION_INDEX_PIXEL_DEFINES_SVH

// same-cycle implication
`define VIP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error("assertion failed");

// next-cycle implication
`define VIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error("assertion failed");

`endif

// ===== hdl/vip_pkg.sv =====
// Shared types, constants and helpers for the vegetation index pixel engine
package vip_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ND_W      = 38;
  localparam int AD_W      = ND_W - 1;
  localparam int Q_W       = 32;
  localparam int REM_W     = AD_W + Q_W + 1;
  localparam int DIV_STAGES = Q_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam longint ONE_L    = longint'(1) << FRAC_BITS;
  localparam longint C016_L   = ((longint'(16) << FRAC_BITS) + 50) / 100;
  localparam longint KELVIN_L = ((longint'(27315) << FRAC_BITS) + 50) / 100;

  localparam logic signed [ND_W-1:0] ONE_Q    = ND_W'(ONE_L);
  localparam logic signed [ND_W-1:0] TWO_Q    = ND_W'(2 * ONE_L);
  localparam logic signed [ND_W-1:0] C016_Q   = ND_W'(C016_L);
  localparam logic signed [ND_W-1:0] KELVIN_Q = ND_W'(KELVIN_L);

  localparam logic [1:0] REG_FORMULA = 2'd0;
  localparam logic [1:0] REG_PRESENT = 2'd1;
  localparam logic [1:0] REG_NODATA  = 2'd2;

  typedef enum logic [4:0] {
    F_NDVI    = 5'd0,
    F_VARI    = 5'd1,
    F_EXG     = 5'd2,
    F_GLI     = 5'd3,
    F_NDWI    = 5'd4,
    F_GNDVI   = 5'd5,
    F_SAVI    = 5'd6,
    F_EVI     = 5'd7,
    F_NDRE    = 5'd8,
    F_NDYI    = 5'd9,
    F_MPRI    = 5'd10,
    F_OSAVI   = 5'd11,
    F_GRVI    = 5'd12,
    F_ENDVI   = 5'd13,
    F_ARVI    = 5'd14,
    F_CELSIUS = 5'd15,
    F_KELVIN  = 5'd16
  } formula_t;

  typedef struct packed {
    logic [4:0]         formula;
    logic [4:0]         present;
    logic signed [31:0] nodata;
  } cfg_t;

  typedef struct packed {
    logic                   is_div;
    logic signed [ND_W-1:0] num;
    logic signed [ND_W-1:0] den;
    logic signed [31:0]     dval;
    logic                   last;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [ND_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[ND_W-1:31]) || !(|v[ND_W-1:31])) begin
      r = v[31:0];
    end else if (v[ND_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ===== hdl/vegetation_index_pixel.sv =====
// Top level of the vegetation index pixel engine
//
// One pixel enters on the s_ group per accepted request: s_tdata carries the
// red, green, blue, near-infrared, red-edge and first-band samples (signed
// fixed point, 32 bits each), s_tlast marks the last pixel of an image.
// Each pixel yields one result on the m_ group: m_tdata is the index value,
// m_tuser flags a nodata result, m_tlast copies the input marker.
// The cfg_ channel writes formula select, band present mask and nodata
// marker; write it only while the pipeline is empty.
// Throughput is one pixel per cycle while m_tready is high. A pixel crosses
// one front end stage, the request queue, two divider setup stages, 32
// restoring divider stages (one quotient bit each) and the output register.
// A stall on m_tready freezes the divider pipeline; the four-entry queue
// and the front end stage keep taking pixels until they fill.
// Reset empties all stages and restores formula 0, band mask 7, nodata 0.
module vegetation_index_pixel import vip_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // red, green, blue, near_ir, red_edge, first_band
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // index_value
  output logic [0:0]   m_tuser,   // is_nodata
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  cfg_t  cfg;
  logic  f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.formula <= 5'd0;
      cfg.present <= 5'd7;
      cfg.nodata  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORMULA: cfg.formula <= cfg_data[4:0];
        REG_PRESENT: cfg.present <= cfg_data[4:0];
        REG_NODATA:  cfg.nodata  <= cfg_data;
        default: ;
      endcase
    end
  end

  vip_front u_front (
    .clk, .rst, .cfg,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata), .in_last(s_tlast),
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  vip_fifo u_fifo (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
  );

  vip_back u_back (
    .clk, .rst, .nodata(cfg.nodata),
    .in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
    .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata),
    .m_nodata(m_tuser[0]), .m_last(m_tlast)
  );

endmodule

// ===== hdl/vip_front.sv =====
// Front end: accepts pixels, checks nodata and builds numerator and denominator or a direct value
module vip_front import vip_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [191:0] in_data,
  input  logic         in_last,
  output logic         out_valid,
  input  logic         out_ready,
  output item_t        out_item
);

  logic signed [31:0]     smp [6];
  logic signed [ND_W-1:0] r, g, b, n, e, t;
  logic                   bad;
  item_t                  nxt;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      smp[i] = in_data[32*i +: 32];
    end
    bad = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (cfg.present[i] && smp[i] == cfg.nodata) begin
        bad = 1'b1;
      end
    end
    r = cfg.present[0] ? ND_W'(smp[0]) : '0;
    g = cfg.present[1] ? ND_W'(smp[1]) : '0;
    b = cfg.present[2] ? ND_W'(smp[2]) : '0;
    n = cfg.present[3] ? ND_W'(smp[3]) : '0;
    e = cfg.present[4] ? ND_W'(smp[4]) : '0;
    t = ND_W'(smp[5]);
    nxt.is_div = 1'b1;
    nxt.num    = '0;
    nxt.den    = '0;
    nxt.dval   = cfg.nodata;
    nxt.last   = in_last;
    case (formula_t'(cfg.formula))
      F_NDVI: begin nxt.num = n - r; nxt.den = n + r; end
      F_VARI: begin nxt.num = g - r; nxt.den = g + r - b; end
      F_EXG: begin
        nxt.is_div = 1'b0;
        nxt.dval   = sat32((g <<< 1) - (r + b));
      end
      F_GLI: begin nxt.num = (g <<< 1) - r - b; nxt.den = (g <<< 1) + r + b; end
      F_NDWI: begin nxt.num = g - n; nxt.den = g + n; end
      F_GNDVI: begin nxt.num = n - g; nxt.den = n + g; end
      F_SAVI: begin nxt.num = 3 * (n - r); nxt.den = ((n + r) <<< 1) + ONE_Q; end
      F_EVI: begin
        nxt.num = 5 * (n - r);
        nxt.den = (n <<< 1) + 12 * r - 15 * b + TWO_Q;
      end
      F_NDRE: begin nxt.num = n - e; nxt.den = n + e; end
      F_NDYI: begin nxt.num = g - b; nxt.den = g + b; end
      F_MPRI: begin nxt.num = g - r; nxt.den = g + r; end
      F_OSAVI: begin nxt.num = n - r; nxt.den = n + r + C016_Q; end
      F_GRVI: begin nxt.num = n; nxt.den = g; end
      F_ENDVI: begin nxt.num = (n + g) - (b <<< 1); nxt.den = (n + g) + (b <<< 1); end
      F_ARVI: begin nxt.num = n - (r <<< 1) + b; nxt.den = n + (r <<< 1) + b; end
      F_CELSIUS: begin
        nxt.is_div = 1'b0;
        nxt.dval   = smp[5];
      end
      F_KELVIN: begin
        nxt.is_div = 1'b0;
        nxt.dval   = (smp[5] == cfg.nodata) ? cfg.nodata : sat32(t + KELVIN_Q);
      end
      default: begin
        nxt.is_div = 1'b0;
      end
    endcase
    if (bad || (nxt.is_div && nxt.den == '0)) begin
      nxt.is_div = 1'b0;
      nxt.dval   = cfg.nodata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_item <= nxt;
    end
  end

endmodule

// ===== hdl/vip_fifo.sv =====
// Short request queue between front end and divider
module vip_fifo import vip_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               push, pop;

  assign in_ready  = count != (FIFO_AW+1)'(FIFO_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== hdl/vip_back.sv =====
// Back end: pipelined rounding divider with saturation and output register
module vip_back import vip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic signed [31:0] nodata,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        m_valid,
  input  logic        m_ready,
  output logic [31:0] m_data,
  output logic        m_nodata,
  output logic        m_last
);

  typedef struct packed {
    logic               valid;
    logic               is_div;
    logic               neg;
    logic               ovf;
    logic               last;
    logic signed [31:0] dval;
    logic [AD_W-1:0]    ad;
    logic [REM_W-1:0]   rem;
    logic [Q_W-1:0]     q;
  } stage_t;

  stage_t             st [DIV_STAGES+2];
  stage_t             entry;
  stage_t             st1_next;
  logic               adv;
  logic [AD_W-1:0]    an;
  logic signed [31:0] res;

  function automatic stage_t div_step(input stage_t s, input int bpos);
    stage_t           o;
    logic [REM_W-1:0] sh;
    o  = s;
    sh = REM_W'(s.ad) << bpos;
    if (s.rem >= sh) begin
      o.rem = s.rem - sh;
      o.q   = {s.q[Q_W-2:0], 1'b1};
    end else begin
      o.q   = {s.q[Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  assign adv      = !m_valid || m_ready;
  assign in_ready = adv;

  always_comb begin
    an           = in_item.num[ND_W-1] ? AD_W'(-in_item.num) : AD_W'(in_item.num);
    entry.valid  = in_valid;
    entry.is_div = in_item.is_div;
    entry.neg    = in_item.num[ND_W-1] ^ in_item.den[ND_W-1];
    entry.ovf    = 1'b0;
    entry.last   = in_item.last;
    entry.dval   = in_item.dval;
    entry.ad     = in_item.den[ND_W-1] ? AD_W'(-in_item.den) : AD_W'(in_item.den);
    entry.rem    = (REM_W'(an) << FRAC_BITS) + REM_W'(entry.ad >> 1);
    entry.q      = '0;
  end

  always_comb begin
    st1_next     = st[0];
    st1_next.ovf = st[0].rem >= (REM_W'(st[0].ad) << Q_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES + 2; k++) begin
        st[k].valid <= 1'b0;
      end
    end else if (adv) begin
      st[0] <= entry;
      st[1] <= st1_next;
      for (int k = 0; k < DIV_STAGES; k++) begin
        st[k+2] <= div_step(st[k+1], Q_W - 1 - k);
      end
    end
  end

  always_comb begin
    if (!st[DIV_STAGES+1].is_div) begin
      res = st[DIV_STAGES+1].dval;
    end else if (st[DIV_STAGES+1].neg) begin
      if (st[DIV_STAGES+1].ovf || st[DIV_STAGES+1].q > 32'h8000_0000) begin
        res = 32'sh8000_0000;
      end else begin
        res = 32'(32'd0 - st[DIV_STAGES+1].q);
      end
    end else begin
      if (st[DIV_STAGES+1].ovf || st[DIV_STAGES+1].q[Q_W-1]) begin
        res = 32'sh7fff_ffff;
      end else begin
        res = st[DIV_STAGES+1].q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= st[DIV_STAGES+1].valid;
    end
    if (adv) begin
      m_data   <= res;
      m_nodata <= res == nodata;
      m_last   <= st[DIV_STAGES+1].last;
    end
  end

endmodule

// ===== hdl/vip_checker.sv =====
// Port checker for the vegetation index pixel engine and its bind
`include "vegetation_index_pixel_defines.svh"
module vip_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  `VIP_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid)
  `VIP_ASSERT_NEXT(a_valid_hold, !rst && m_tvalid && !m_tready, m_tvalid || rst)
  `VIP_ASSERT_NEXT(a_data_hold, !rst && m_tvalid && !m_tready, $stable(m_tdata) || rst)
  `VIP_ASSERT_NOW(a_cfg_taken, cfg_valid, cfg_ready)

endmodule

bind vegetation_index_pixel vip_checker u_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the vegetation index pixel engine
`timescale 1ns / 100ps

module tb_top;
  import vip_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;   // red, green, blue, near_ir, red_edge, first_band
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;        // index_value
  logic [0:0]   m_tuser;        // is_nodata
  logic         m_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  vegetation_index_pixel dut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic signed [31:0] value;
    logic               nodata;
    logic               last;
  } index_result_t;

  typedef struct {
    logic [31:0] band[6];
    logic        last;
    logic        has_exp;
    logic [31:0] exp_value;
    logic        exp_nodata;
  } pixel_row_t;

  logic [4:0]         cur_formula;
  logic [4:0]         cur_present;
  logic signed [31:0] cur_nodata;
  index_result_t      index_q[$];
  int                 errors = 0;
  bit                 stall_hold = 0;
  bit                 calm = 0;
  longint             c016 = ((longint'(16) << FRAC_BITS) + 50) / 100;
  longint             kelv = ((longint'(27315) << FRAC_BITS) + 50) / 100;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_quot(longint num, longint den);
    bit      neg;
    longint  an, ad, q;
    neg = (num < 0) != (den < 0);
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = ((an << FRAC_BITS) + ad / 2) / ad;
    if (neg) return q > 64'sd2147483648 ? -64'sd2147483648 : -q;
    return q > 64'sd2147483647 ? 64'sd2147483647 : q;
  endfunction

  function automatic index_result_t predict_index(logic [31:0] band[6], logic last);
    longint        v[5];
    longint        num, den, res, t;
    bit            bad, div;
    index_result_t r;
    bad = 0;
    for (int i = 0; i < 5; i++) begin
      v[i] = cur_present[i] ? longint'($signed(band[i])) : 0;
      if (cur_present[i] && $signed(band[i]) == cur_nodata) bad = 1;
    end
    t = longint'($signed(band[5]));
    num = 0; den = 0; div = 1;
    res = cur_nodata;
    if (!bad) begin
      case (cur_formula)
        F_NDVI:  begin num = v[3] - v[0]; den = v[3] + v[0]; end
        F_VARI:  begin num = v[1] - v[0]; den = v[1] + v[0] - v[2]; end
        F_EXG:   begin div = 0; res = clip32(2 * v[1] - (v[0] + v[2])); end
        F_GLI:   begin num = 2 * v[1] - v[0] - v[2]; den = 2 * v[1] + v[0] + v[2]; end
        F_NDWI:  begin num = v[1] - v[3]; den = v[1] + v[3]; end
        F_GNDVI: begin num = v[3] - v[1]; den = v[3] + v[1]; end
        F_SAVI:  begin
          num = 3 * (v[3] - v[0]); den = 2 * (v[3] + v[0]) + (longint'(1) << FRAC_BITS);
        end
        F_EVI:   begin
          num = 5 * (v[3] - v[0]);
          den = 2 * v[3] + 12 * v[0] - 15 * v[2] + 2 * (longint'(1) << FRAC_BITS);
        end
        F_NDRE:  begin num = v[3] - v[4]; den = v[3] + v[4]; end
        F_NDYI:  begin num = v[1] - v[2]; den = v[1] + v[2]; end
        F_MPRI:  begin num = v[1] - v[0]; den = v[1] + v[0]; end
        F_OSAVI: begin num = v[3] - v[0]; den = v[3] + v[0] + c016; end
        F_GRVI:  begin num = v[3]; den = v[1]; end
        F_ENDVI: begin num = v[3] + v[1] - 2 * v[2]; den = v[3] + v[1] + 2 * v[2]; end
        F_ARVI:  begin num = v[3] - 2 * v[0] + v[2]; den = v[3] + 2 * v[0] + v[2]; end
        F_CELSIUS: begin div = 0; res = t; end
        F_KELVIN:  begin div = 0; res = (t == cur_nodata) ? cur_nodata : clip32(t + kelv); end
        default: begin div = 0; res = cur_nodata; end
      endcase
      if (div) res = (den == 0) ? cur_nodata : round_quot(num, den);
    end
    r.value = res[31:0];
    r.nodata = (res == cur_nodata);
    r.last = last;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FORMULA: cur_formula = val[4:0];
      REG_PRESENT: cur_present = val[4:0];
      REG_NODATA:  cur_nodata = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (index_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_pixel(logic [31:0] band[6], logic last);
    while (!calm && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= {band[5], band[4], band[3], band[2], band[1], band[0]};
    s_tlast <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    index_q.insert(index_q.size(), predict_index(band, last));
  endtask

  function automatic logic [31:0] rand_sample(logic signed [31:0] nd);
    case ($urandom_range(9))
      0: return nd;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'($signed($urandom_range(8)) - 4);
      4, 5: return 32'($signed($urandom_range(1 << 17)) - (1 << 16));
      6: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !stall_hold && (calm || $urandom_range(99) >= 10);
      if (m_tvalid && m_tready) begin
        if (index_q.size() == 0) begin
          $error("unexpected result %h", m_tdata);
          errors++;
        end else begin
          index_result_t e;
          e = index_q.pop_front();
          if (m_tdata !== e.value) begin
            $error("index_value expected %h actual %h", e.value, m_tdata);
            errors++;
          end
          if (m_tuser[0] !== e.nodata) begin
            $error("is_nodata expected %b actual %b", e.nodata, m_tuser[0]);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("last expected %b actual %b", e.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    pixel_row_t          rows[$];
    pixel_row_t          row;
    logic [31:0]         b[6];
    index_result_t       got;
    int                  count;
    cur_formula = 0;
    cur_present = 7;
    cur_nodata = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config, NDVI over red/green/blue only
    row.band = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 0, 0};
    row.last = 0; row.has_exp = 1; row.exp_value = 32'hffff_0000; row.exp_nodata = 0;
    rows.insert(rows.size(), row);
    row.band = '{0, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1};
    row.last = 1; row.exp_value = 0; row.exp_nodata = 1;
    rows.insert(rows.size(), row);
    foreach (rows[i]) begin
      send_pixel(rows[i].band, rows[i].last);
      if (rows[i].has_exp) begin
        got = index_q[$];
        if (got.value !== rows[i].exp_value || got.nodata !== rows[i].exp_nodata) begin
          $error("directed row %0d expected %h actual %h", i, rows[i].exp_value, got.value);
          errors++;
        end
      end
    end
    s_tvalid <= 1'b0;
    drain();

    // directed: every formula with all bands present, extremes included
    write_reg(REG_PRESENT, 32'h1f);
    write_reg(REG_NODATA, 32'h8000_0000);
    write_reg(REG_UNUSED, 32'h0);
    for (int f = 0; f < 18; f++) begin
      write_reg(REG_FORMULA, f);
      b = '{32'h0000_8000, 32'h0001_0000, 32'h0000_4000, 32'h0003_0000,
            32'h0001_8000, 32'hfff0_0000};
      send_pixel(b, 0);
      b = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_ffff,
            32'h8000_0001, 32'h7fff_ffff};
      send_pixel(b, f == 17);
      s_tvalid <= 1'b0;
      drain();
    end

    // random phases
    for (int p = 0; p < 24; p++) begin
      write_reg(REG_FORMULA, p < 17 ? p : $urandom_range(31));
      write_reg(REG_PRESENT, p == 3 ? 0 : (p == 5 ? 32'h1f : $urandom_range(31)));
      write_reg(REG_NODATA, p == 7 ? 32'h7fff_ffff : (p % 3 == 0 ? 0 : $urandom));
      calm = (p == 10);
      if (p == 12) begin
        fork
          begin
            stall_hold = 1;
            repeat (200) @(posedge clk);
            stall_hold = 0;
          end
        join_none
      end
      count = 80;
      for (int n = 0; n < count; n++) begin
        for (int k = 0; k < 6; k++) b[k] = rand_sample(cur_nodata);
        send_pixel(b, (n == count - 1) || ($urandom_range(31) == 0));
      end
      s_tvalid <= 1'b0;
      calm = 0;
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== vegetation_index_pixel.f =====
+incdir+hdl
hdl/vip_pkg.sv
hdl/vip_front.sv
hdl/vip_fifo.sv
hdl/vip_back.sv
hdl/vegetation_index_pixel.sv
hdl/vip_checker.sv
dv/tb_top.sv
